@@ hw/rtl/bwa_pkg.sv @@
// bwa_pkg: shared types and constants for the bone weight assignment block
// no dependencies; used by every module under hw/rtl
package bwa_pkg;

	// field widths
	localparam int XW     = 24;   // vertex_x, signed q11.12
	localparam int SPW    = 16;   // bone_spacing, unsigned q4.12
	localparam int ACTW   = 4;    // active_bones
	localparam int IDW    = 4;    // bone id on the result
	localparam int WW     = 17;   // q1.16 weight, 65536 is one
	localparam int TOTW   = SPW + 1;
	localparam int POSW   = SPW + 6;  // bone index up to 63 times spacing
	localparam int DW     = POSW + 4; // signed distance
	localparam int QUOW   = WW;       // quotient bits, one per divider stage

	localparam logic [WW-1:0] Q_ONE = WW'(65536);

	// delay from request to result, summed over tent, pick, divider and output
	localparam int LATENCY = QUOW + 3;

	typedef enum logic [0:0] {
		CFG_SPACING = 1'b0,
		CFG_ACTIVE  = 1'b1
	} cfg_idx_t;

	// side information that travels alongside the divider
	typedef struct packed {
		logic [IDW-1:0] id;      // lower influencing bone
		logic           zero;    // every tent was zero
	} meta_t;

endpackage

@@ hw/rtl/bwa_tent.sv @@
// bwa_tent: per-bone tent lanes (stage 1) and lower bone pick with total (stage 2)
// depends on bwa_pkg
module bwa_tent #(
	parameter int NUM_BONES = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	input  logic signed [bwa_pkg::XW-1:0]   x,
	input  logic [bwa_pkg::SPW-1:0]         spacing,
	input  logic [bwa_pkg::ACTW-1:0]        active,
	output logic                            vld_s2,
	output logic [bwa_pkg::SPW-1:0]         raw_lo_s2,
	output logic [bwa_pkg::TOTW-1:0]        total_s2,
	output bwa_pkg::meta_t                  meta_s2
);

	logic                    vld_s1;
	logic [bwa_pkg::SPW-1:0] raw_s1 [NUM_BONES];
	logic [bwa_pkg::SPW-1:0] raw_c  [NUM_BONES];

	// one lane per bone
	for (genvar b = 0; b < NUM_BONES; b++) begin : g_lane
		logic [bwa_pkg::POSW-1:0]      pos;
		logic signed [bwa_pkg::DW-1:0] dlt, adlt, r;
		always_comb begin
			pos  = bwa_pkg::POSW'(b) * bwa_pkg::POSW'(spacing);
			dlt  = signed'(bwa_pkg::DW'(pos)) - bwa_pkg::DW'(x);
			adlt = dlt[bwa_pkg::DW-1] ? -dlt : dlt;
			r    = signed'(bwa_pkg::DW'(spacing)) - adlt;
			if (!r[bwa_pkg::DW-1] && r != '0 && bwa_pkg::DW'(b) < bwa_pkg::DW'(active)) begin
				raw_c[b] = r[bwa_pkg::SPW-1:0];
			end else begin
				raw_c[b] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= raw_c;
	end

	// first bone with a tent, and its upper neighbour
	logic                     found;
	logic [bwa_pkg::SPW-1:0]  lo_c, hi_c;
	logic [bwa_pkg::IDW-1:0]  id_c;
	always_comb begin
		found = 1'b0;
		lo_c  = '0;
		hi_c  = '0;
		id_c  = '0;
		for (int b = 0; b < NUM_BONES; b++) begin
			if (!found && raw_s1[b] != '0) begin
				found = 1'b1;
				lo_c  = raw_s1[b];
				id_c  = bwa_pkg::IDW'(b);
				hi_c  = (b + 1 < NUM_BONES) ? raw_s1[(b + 1) % NUM_BONES] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		raw_lo_s2    <= lo_c;
		total_s2     <= bwa_pkg::TOTW'(lo_c) + bwa_pkg::TOTW'(hi_c);
		meta_s2.id   <= id_c;
		meta_s2.zero <= !found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

endmodule

@@ hw/rtl/bwa_div.sv @@
// bwa_div: pipelined restoring divider, one quotient bit per stage, q = a * 2^16 / t
// depends on bwa_pkg
module bwa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [bwa_pkg::SPW-1:0]     num,
	input  logic [bwa_pkg::TOTW-1:0]    den,
	input  bwa_pkg::meta_t              meta_in,
	output logic                        out_vld,
	output logic [bwa_pkg::QUOW-1:0]    quo,
	output logic                        rem_nz,
	output bwa_pkg::meta_t              meta_out
);

	localparam int N = bwa_pkg::QUOW;
	localparam int RW = bwa_pkg::TOTW;

	logic                    vld_s [N];
	logic [RW-1:0]           rem_s [N];
	logic [bwa_pkg::QUOW-1:0] quo_s [N];
	logic [RW-1:0]           den_s [N];
	bwa_pkg::meta_t          meta_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW:0]               trial, diff;
		logic                      ge;
		logic [RW-1:0]             d_in;
		logic [bwa_pkg::QUOW-1:0]  q_in;
		bwa_pkg::meta_t            m_in;
		logic                      v_in;
		always_comb begin
			if (k == 0) begin
				trial = (RW + 1)'(num);
				d_in  = den;
				q_in  = '0;
				m_in  = meta_in;
				v_in  = in_vld;
			end else begin
				trial = {rem_s[(k + N - 1) % N], 1'b0};
				d_in  = den_s[(k + N - 1) % N];
				q_in  = quo_s[(k + N - 1) % N];
				m_in  = meta_s[(k + N - 1) % N];
				v_in  = vld_s[(k + N - 1) % N];
			end
			ge   = trial >= {1'b0, d_in};
			diff = trial - {1'b0, d_in};
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
			quo_s[k]  <= {q_in[bwa_pkg::QUOW-2:0], ge};
			den_s[k]  <= d_in;
			meta_s[k] <= m_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign quo      = quo_s[N-1];
	assign rem_nz   = rem_s[N-1] != '0;
	assign meta_out = meta_s[N-1];

endmodule

@@ hw/rtl/bwa_out.sv @@
// bwa_out: second weight, slot fill and parity sums, registered result
// depends on bwa_pkg
module bwa_out #(
	parameter int SLOTS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [bwa_pkg::QUOW-1:0]    quo,
	input  logic                        rem_nz,
	input  bwa_pkg::meta_t              meta,
	output logic                        done,
	output logic [bwa_pkg::IDW-1:0]     bone_id_a,
	output logic [bwa_pkg::IDW-1:0]     bone_id_b,
	output logic [bwa_pkg::IDW-1:0]     bone_id_c,
	output logic [bwa_pkg::IDW-1:0]     bone_id_d,
	output logic [bwa_pkg::WW-1:0]      weight_a,
	output logic [bwa_pkg::WW-1:0]      weight_b,
	output logic [bwa_pkg::WW-1:0]      weight_c,
	output logic [bwa_pkg::WW-1:0]      weight_d,
	output logic [bwa_pkg::WW-1:0]      odd_bone_sum,
	output logic [bwa_pkg::WW-1:0]      even_bone_sum,
	output logic                        no_influence
);

	logic [bwa_pkg::WW-1:0]  w_lo, w_hi, odd_c, even_c, wa_c, wb_c;
	logic [bwa_pkg::IDW-1:0] id_hi, ida_c, idb_c;
	logic                    lo_ok, hi_ok;

	always_comb begin
		w_lo  = bwa_pkg::WW'(quo);
		// the two weights sum to one, less one lsb when the division is inexact
		w_hi  = bwa_pkg::Q_ONE - w_lo - bwa_pkg::WW'(rem_nz);
		id_hi = meta.id + bwa_pkg::IDW'(1);
		lo_ok = w_lo != '0;
		hi_ok = w_hi != '0;
		ida_c = '0;
		wa_c  = '0;
		idb_c = '0;
		wb_c  = '0;
		if (lo_ok) begin
			ida_c = meta.id;
			wa_c  = w_lo;
			if (hi_ok && SLOTS >= 2) begin
				idb_c = id_hi;
				wb_c  = w_hi;
			end
		end else if (hi_ok) begin
			ida_c = id_hi;
			wa_c  = w_hi;
		end
		if (meta.id[0]) begin
			odd_c  = w_lo;
			even_c = w_hi;
		end else begin
			odd_c  = w_hi;
			even_c = w_lo;
		end
		if (meta.zero) begin
			ida_c  = '0;
			wa_c   = '0;
			idb_c  = '0;
			wb_c   = '0;
			odd_c  = '0;
			even_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		bone_id_a     <= ida_c;
		bone_id_b     <= idb_c;
		weight_a      <= wa_c;
		weight_b      <= wb_c;
		odd_bone_sum  <= odd_c;
		even_bone_sum <= even_c;
		no_influence  <= meta.zero;
	end

	// two tents at most overlap, so the last two slots stay empty
	assign bone_id_c = '0;
	assign bone_id_d = '0;
	assign weight_c  = '0;
	assign weight_d  = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_vld;
		end
	end

endmodule

@@ hw/rtl/bone_weight_assign.sv @@
// bone_weight_assign: top level, configuration registers and pipeline wiring
// depends on bwa_pkg, bwa_tent, bwa_div, bwa_out
//
// channel    signals                              direction  handshake
// request    start, busy, vertex_x                in         start && !busy
// result     done, bone_id_*, weight_*, sums,     out        done strobe, one cycle
//            no_influence
// config     cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//            cfg_data
//
// one request per cycle; each result follows its request through tent, pick, divider and output
// most of the pipeline is the divider, one quotient bit per stage over 17 stages
// busy is never raised: the pipeline always advances and the receiver cannot stall
// reset clears the valid bits and loads spacing 4.0 and ten active bones
module bone_weight_assign #(
	parameter int NUM_BONES = 10,
	parameter int SLOTS     = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [bwa_pkg::XW-1:0]   vertex_x,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [0:0]                      cfg_index,
	input  logic [bwa_pkg::SPW-1:0]         cfg_data,
	output logic                            done,
	output logic [bwa_pkg::IDW-1:0]         bone_id_a,
	output logic [bwa_pkg::IDW-1:0]         bone_id_b,
	output logic [bwa_pkg::IDW-1:0]         bone_id_c,
	output logic [bwa_pkg::IDW-1:0]         bone_id_d,
	output logic [bwa_pkg::WW-1:0]          weight_a,
	output logic [bwa_pkg::WW-1:0]          weight_b,
	output logic [bwa_pkg::WW-1:0]          weight_c,
	output logic [bwa_pkg::WW-1:0]          weight_d,
	output logic [bwa_pkg::WW-1:0]          odd_bone_sum,
	output logic [bwa_pkg::WW-1:0]          even_bone_sum,
	output logic                            no_influence
);

	logic [bwa_pkg::SPW-1:0]  spacing_q;
	logic [bwa_pkg::ACTW-1:0] active_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= bwa_pkg::SPW'(16384);
			active_q  <= bwa_pkg::ACTW'(10);
		end else if (cfg_valid && cfg_ready) begin
			case (bwa_pkg::cfg_idx_t'(cfg_index))
				bwa_pkg::CFG_SPACING: spacing_q <= cfg_data;
				bwa_pkg::CFG_ACTIVE:  active_q  <= cfg_data[bwa_pkg::ACTW-1:0];
				default: ;
			endcase
		end
	end

	// tents and pick of the lower bone
	logic                         vld_s2;
	logic [bwa_pkg::SPW-1:0]      raw_lo_s2;
	logic [bwa_pkg::TOTW-1:0]     total_s2;
	bwa_pkg::meta_t               meta_s2;

	bwa_tent #(.NUM_BONES(NUM_BONES)) u_tent (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start && !busy),
		.x         (vertex_x),
		.spacing   (spacing_q),
		.active    (active_q),
		.vld_s2    (vld_s2),
		.raw_lo_s2 (raw_lo_s2),
		.total_s2  (total_s2),
		.meta_s2   (meta_s2)
	);

	// normalise the lower tent against the total
	logic                         div_vld;
	logic [bwa_pkg::QUOW-1:0]     div_quo;
	logic                         div_rem_nz;
	bwa_pkg::meta_t               div_meta;

	bwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.num      (raw_lo_s2),
		.den      (total_s2),
		.meta_in  (meta_s2),
		.out_vld  (div_vld),
		.quo      (div_quo),
		.rem_nz   (div_rem_nz),
		.meta_out (div_meta)
	);

	// slots and parity sums
	bwa_out #(.SLOTS(SLOTS)) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (div_vld),
		.quo           (div_quo),
		.rem_nz        (div_rem_nz),
		.meta          (div_meta),
		.done          (done),
		.bone_id_a     (bone_id_a),
		.bone_id_b     (bone_id_b),
		.bone_id_c     (bone_id_c),
		.bone_id_d     (bone_id_d),
		.weight_a      (weight_a),
		.weight_b      (weight_b),
		.weight_c      (weight_c),
		.weight_d      (weight_d),
		.odd_bone_sum  (odd_bone_sum),
		.even_bone_sum (even_bone_sum),
		.no_influence  (no_influence)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(bwa_pkg::LATENCY) done)
		else $error("result missing after request");

	a_first_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && !no_influence |-> weight_a != '0)
		else $error("first slot empty with influence");

	a_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		done && no_influence |-> weight_a == '0 && odd_bone_sum == '0 && even_bone_sum == '0)
		else $error("outputs not cleared without influence");

	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		done && !no_influence |->
			(18'(odd_bone_sum) + 18'(even_bone_sum) == 18'(65536)) ||
			(18'(odd_bone_sum) + 18'(even_bone_sum) == 18'(65535)))
		else $error("weights do not sum to one");
`endif

endmodule
